// File: rtl/was_pkg.sv
// Shared types, constants and helpers of the widget animation step pipeline.
`timescale 1ns / 1ps
`default_nettype none
package was_pkg;

    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = 6;

    localparam logic [9:0]  US_PER_MS   = 10'd1000;
    // floor(r / 1000) == (r * RECIP_1000) >> RECIP_SHIFT for every r below 2^25
    localparam logic [25:0] RECIP_1000  = 26'd34359739;
    localparam int          RECIP_SHIFT = 35;
    // floor(x / 15) == (x * RECIP_15) >> 16 for every x below 2^12
    localparam logic [12:0] RECIP_15    = 13'd4370;
    localparam int          RECIP_15_SH = 16;

    localparam logic [3:0] MASK_X   = 4'b0001;
    localparam logic [3:0] MASK_Y   = 4'b0010;
    localparam logic [3:0] MASK_FG  = 4'b0100;
    localparam logic [3:0] MASK_VIS = 4'b1000;

    typedef enum logic [2:0] {
        MODE_NONE     = 3'd0,
        MODE_BLINK    = 3'd1,
        MODE_FADE_IN  = 3'd2,
        MODE_FADE_OUT = 3'd3,
        MODE_SLIDE    = 3'd4,
        MODE_PULSE    = 3'd5,
        MODE_BOUNCE   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  dir;
        logic [14:0] dur;
        logic        neg;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [7:0]  ofg;
        logic        ovis;
        logic [15:0] ww;
        logic [15:0] wh;
        logic        done;
    } fld_t;

    typedef struct packed {
        fld_t        f;
        logic [24:0] du;
        logic [47:0] dvd;
        logic [24:0] rem;
        logic        qlsb;
        logic        qnz;
    } div_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  fg_level;
        logic        visible;
        logic [3:0]  write_mask;
        logic        done_out;
        logic        running;
    } res_t;

    function automatic logic [15:0] clamp_coord(input logic signed [19:0] v);
        logic [15:0] r;
        if (v < 20'sd0) begin
            r = 16'd0;
        end else if (v > 20'sd65535) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/was_div_stage.sv
// One registered stage of eight restoring division steps.
`timescale 1ns / 1ps
`default_nettype none
module was_div_stage (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  was_pkg::div_t    in_d,
    output logic             out_valid,
    output was_pkg::div_t    out_d
);

    logic          valid_reg;
    was_pkg::div_t data_reg;
    was_pkg::div_t data_next;

    always_comb begin
        logic [25:0] t;
        data_next = in_d;
        for (int i = 0; i < was_pkg::DIV_STEPS; i++) begin
            t = {data_next.rem, data_next.dvd[47]};
            data_next.dvd = {data_next.dvd[46:0], 1'b0};
            if (t >= {1'b0, data_next.du}) begin
                data_next.rem  = 25'(t - {1'b0, data_next.du});
                data_next.qlsb = 1'b1;
                data_next.qnz  = 1'b1;
            end else begin
                data_next.rem  = t[24:0];
                data_next.qlsb = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_d     = data_reg;

endmodule
`default_nettype wire

// File: rtl/was_tail.sv
// Fraction, phase, scaling and result stages after the long division.
`timescale 1ns / 1ps
`default_nettype none
module was_tail (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  was_pkg::div_t    in_d,
    output logic             out_valid,
    output was_pkg::res_t    out_r
);

    typedef struct packed {
        was_pkg::fld_t f;
        logic          qlsb;
        logic          qnz;
        logic [7:0]    f8;
        logic          fnz;
        logic [3:0]    p15;
        logic [14:0]   ph;
    } t1_t;

    typedef struct packed {
        was_pkg::fld_t      f;
        logic               qlsb;
        logic               qnz;
        logic [14:0]        hf;
        logic [19:0]        num;
        logic signed [27:0] sx;
        logic signed [27:0] sy;
        logic [11:0]        fprod;
    } t2_t;

    typedef struct packed {
        was_pkg::fld_t f;
        logic          qlsb;
        logic          qnz;
        logic [5:0]    q6;
        logic [15:0]   spx;
        logic [15:0]   spy;
        logic [7:0]    fgv;
    } t3_t;

    typedef struct packed {
        was_pkg::fld_t f;
        logic          qlsb;
        logic          qnz;
        logic [15:0]   spx;
        logic [15:0]   spy;
        logic [7:0]    fgv;
        logic [6:0]    lo;
        logic [11:0]   pp;
        logic [15:0]   bpy;
    } t4_t;

    logic [3:0]    valid_reg;
    logic          out_valid_reg;
    t1_t           t1_reg, t1_next;
    t2_t           t2_reg, t2_next;
    t3_t           t3_reg, t3_next;
    t4_t           t4_reg, t4_next;
    was_pkg::res_t res_reg, res_next;

    // fractional bits of r/du, floor(15r/du) and the millisecond phase
    always_comb begin
        logic [24:0] fr;
        logic [25:0] t;
        logic [28:0] n15;
        logic [24:0] pr;
        logic [50:0] prod;
        t1_next.f    = in_d.f;
        t1_next.qlsb = in_d.qlsb;
        t1_next.qnz  = in_d.qnz;
        t1_next.f8   = '0;
        t1_next.p15  = '0;
        fr = in_d.rem;
        for (int i = 0; i < 8; i++) begin
            t = {fr, 1'b0};
            if (t >= {1'b0, in_d.du}) begin
                fr = 25'(t - {1'b0, in_d.du});
                t1_next.f8[7-i] = 1'b1;
            end else begin
                fr = t[24:0];
            end
        end
        t1_next.fnz = |fr;
        n15 = {in_d.rem, 4'b0000} - {4'b0000, in_d.rem};
        pr  = n15[28:4];
        for (int i = 0; i < 4; i++) begin
            t = {pr, n15[3-i]};
            if (t >= {1'b0, in_d.du}) begin
                pr = 25'(t - {1'b0, in_d.du});
                t1_next.p15[3-i] = 1'b1;
            end else begin
                pr = t[24:0];
            end
        end
        prod = 51'(in_d.rem) * 51'(was_pkg::RECIP_1000);
        t1_next.ph = prod[was_pkg::RECIP_SHIFT +: 15];
    end

    // triangle numerator, slide offsets and fade product
    always_comb begin
        logic [4:0]         amp;
        logic [4:0]         kk;
        logic [14:0]        base;
        logic [8:0]         rem9;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic [3:0]         fm;
        t2_next.f    = t1_reg.f;
        t2_next.qlsb = t1_reg.qlsb;
        t2_next.qnz  = t1_reg.qnz;
        t2_next.hf   = (t1_reg.f.dur[14:1] == 14'd0) ? 15'd1 : {1'b0, t1_reg.f.dur[14:1]};
        if (t1_reg.f.wh[15:1] == 15'd0) begin
            amp = 5'd1;
        end else if (t1_reg.f.wh[15:1] > 15'd16) begin
            amp = 5'd16;
        end else begin
            amp = t1_reg.f.wh[5:1];
        end
        kk = (t1_reg.f.mode == was_pkg::MODE_PULSE) ? 5'd15 : amp;
        if (t1_reg.f.neg || (t1_reg.ph < t2_next.hf)) begin
            base = t1_reg.ph;
        end else begin
            base = t1_reg.f.dur - t1_reg.ph;
        end
        t2_next.num = 20'(base) * 20'(kk);
        rem9 = 9'd256 - 9'(t1_reg.f8) - 9'(t1_reg.fnz);
        dx = 18'sd0;
        dy = 18'sd0;
        case (t1_reg.f.dir)
            was_pkg::DIR_LEFT: begin
                dx = -$signed({2'b00, t1_reg.f.ww}) - $signed({{2{t1_reg.f.ox[15]}}, t1_reg.f.ox});
            end
            was_pkg::DIR_RIGHT: begin
                dx = 18'sd256;
            end
            was_pkg::DIR_UP: begin
                dy = -$signed({2'b00, t1_reg.f.wh}) - $signed({{2{t1_reg.f.oy[15]}}, t1_reg.f.oy});
            end
            default: begin
                dy = 18'sd128;
            end
        endcase
        t2_next.sx = dx * $signed({1'b0, rem9});
        t2_next.sy = dy * $signed({1'b0, rem9});
        fm = (t1_reg.f.mode == was_pkg::MODE_FADE_IN) ? t1_reg.p15 : 4'd15 - t1_reg.p15;
        t2_next.fprod = 12'(t1_reg.f.ofg) * 12'(fm);
    end

    // divide by the half period, finish slide and fade values
    always_comb begin
        logic [14:0]        rr;
        logic [15:0]        t;
        logic signed [27:0] ax;
        logic signed [27:0] ay;
        logic signed [27:0] tx;
        logic signed [27:0] ty;
        logic [24:0]        fp;
        t3_next.f    = t2_reg.f;
        t3_next.qlsb = t2_reg.qlsb;
        t3_next.qnz  = t2_reg.qnz;
        t3_next.q6   = '0;
        rr = {1'b0, t2_reg.num[19:6]};
        for (int i = 0; i < 6; i++) begin
            t = {rr, t2_reg.num[5-i]};
            if (t >= {1'b0, t2_reg.hf}) begin
                rr = 15'(t - {1'b0, t2_reg.hf});
                t3_next.q6[5-i] = 1'b1;
            end else begin
                rr = t[14:0];
            end
        end
        // round toward zero before the shift
        ax = t2_reg.sx[27] ? t2_reg.sx + 28'sd255 : t2_reg.sx;
        ay = t2_reg.sy[27] ? t2_reg.sy + 28'sd255 : t2_reg.sy;
        tx = ax >>> 8;
        ty = ay >>> 8;
        t3_next.spx = was_pkg::clamp_coord(
            $signed({{4{t2_reg.f.ox[15]}}, t2_reg.f.ox}) + $signed(tx[19:0]));
        t3_next.spy = was_pkg::clamp_coord(
            $signed({{4{t2_reg.f.oy[15]}}, t2_reg.f.oy}) + $signed(ty[19:0]));
        fp = 25'(t2_reg.fprod) * 25'(was_pkg::RECIP_15);
        t3_next.fgv = fp[was_pkg::RECIP_15_SH +: 8];
    end

    // pulse level product and bounce position
    always_comb begin
        logic [3:0]        pv;
        logic signed [6:0] off;
        t4_next.f    = t3_reg.f;
        t4_next.qlsb = t3_reg.qlsb;
        t4_next.qnz  = t3_reg.qnz;
        t4_next.spx  = t3_reg.spx;
        t4_next.spy  = t3_reg.spy;
        t4_next.fgv  = t3_reg.fgv;
        if (t3_reg.f.neg) begin
            pv = 4'd0;
        end else if (t3_reg.q6 > 6'd15) begin
            pv = 4'd15;
        end else begin
            pv = t3_reg.q6[3:0];
        end
        t4_next.lo = t3_reg.f.ofg[7:1];
        t4_next.pp = 12'(t3_reg.f.ofg - {1'b0, t3_reg.f.ofg[7:1]}) * 12'(pv);
        off = t3_reg.f.neg ? -$signed({1'b0, t3_reg.q6}) : $signed({1'b0, t3_reg.q6});
        t4_next.bpy = was_pkg::clamp_coord(
            $signed({{4{t3_reg.f.oy[15]}}, t3_reg.f.oy}) - $signed({{13{off[6]}}, off}));
    end

    // select the written fields by mode
    always_comb begin
        logic [24:0] pq;
        logic [8:0]  fpul;
        logic        dur_nz;
        logic        act;
        pq     = 25'(t4_reg.pp) * 25'(was_pkg::RECIP_15);
        fpul   = {2'b00, t4_reg.lo} + {1'b0, pq[was_pkg::RECIP_15_SH +: 8]};
        dur_nz = |t4_reg.f.dur;
        act    = dur_nz && !t4_reg.f.done;
        res_next          = '0;
        res_next.done_out = t4_reg.f.done;
        case (t4_reg.f.mode)
            was_pkg::MODE_BLINK: begin
                res_next.running = 1'b1;
                if (dur_nz) begin
                    res_next.visible    = t4_reg.qlsb ? 1'b0 : t4_reg.f.ovis;
                    res_next.write_mask = was_pkg::MASK_VIS;
                end
            end
            was_pkg::MODE_FADE_IN, was_pkg::MODE_FADE_OUT: begin
                if (act) begin
                    if (t4_reg.f.mode == was_pkg::MODE_FADE_IN) begin
                        res_next.fg_level   = t4_reg.qnz ? t4_reg.f.ofg : t4_reg.fgv;
                        res_next.visible    = t4_reg.f.ovis;
                        res_next.write_mask = was_pkg::MASK_FG | was_pkg::MASK_VIS;
                    end else begin
                        res_next.fg_level   = t4_reg.qnz ? 8'd0 : t4_reg.fgv;
                        res_next.write_mask = was_pkg::MASK_FG;
                    end
                    res_next.done_out = t4_reg.qnz;
                end
                res_next.running = !res_next.done_out;
            end
            was_pkg::MODE_SLIDE: begin
                if (act) begin
                    res_next.pos_x      = t4_reg.qnz ? t4_reg.f.ox : t4_reg.spx;
                    res_next.pos_y      = t4_reg.qnz ? t4_reg.f.oy : t4_reg.spy;
                    res_next.write_mask = was_pkg::MASK_X | was_pkg::MASK_Y;
                    res_next.done_out   = t4_reg.qnz;
                end
                res_next.running = !res_next.done_out;
            end
            was_pkg::MODE_PULSE: begin
                res_next.running = 1'b1;
                if (dur_nz) begin
                    res_next.fg_level   = (fpul > 9'd15) ? 8'd15 : fpul[7:0];
                    res_next.write_mask = was_pkg::MASK_FG;
                end
            end
            was_pkg::MODE_BOUNCE: begin
                res_next.running = 1'b1;
                if (dur_nz) begin
                    res_next.pos_y      = t4_reg.bpy;
                    res_next.write_mask = was_pkg::MASK_Y;
                end
            end
            default: begin
                res_next.running = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= {valid_reg[2:0], in_valid};
            out_valid_reg <= valid_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            t3_reg  <= t3_next;
            t4_reg  <= t4_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_r     = res_reg;

endmodule
`default_nettype wire

// File: rtl/widget_animation_step_top.sv
// Top level of the widget animation step pipeline.
//
//  channel  | dir | tdata                                   | tuser       | tlast
//  ---------+-----+-----------------------------------------+-------------+------
//  s_       | in  | 144 bits, slot fields                   | mode        | none
//  m_       | out | 48 bits, position, level, flags         | write_mask  | none
//
// One transaction enters per cycle unless m_tready stalls the pipe; each result
// passes the input register, divisor set-up, six stages of the 48-step long division
// of the elapsed time magnitude by the period in microseconds, and five finishing
// stages.
// The long division sets the depth; every stage is one register deep.
// aresetn (synchronous) clears the valid bits only; payload registers hold.
// A stall at m_tready freezes every stage together, so nothing is dropped
// or repeated, and s_tready stays high while the output register is free
// or being emptied.
`timescale 1ns / 1ps
`default_nettype none
module widget_animation_step_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // slide_dir[1:0], period_ms[16:2], elapsed_time[64:17], orig_x[80:65],
    // orig_y[96:81], orig_fg[104:97], orig_vis[105], widget_width[121:106],
    // widget_height[137:122], done_in[138], zero fill[143:139]
    input  wire logic [143:0] s_tdata,
    // mode[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x[15:0], pos_y[31:16], fg_level[39:32], visible[40], done_out[41],
    // running[42], zero fill[47:43]
    output logic [47:0]       m_tdata,
    // write_mask[3:0]
    output logic [3:0]        m_tuser
);

    logic                en;
    logic                v0_reg;
    was_pkg::fld_t       f0_reg;
    logic [47:0]         el0_reg;
    logic                v1_reg;
    was_pkg::div_t       d1_reg;
    was_pkg::div_t       d1_next;
    logic                dv_valid [0:was_pkg::DIV_STAGES];
    was_pkg::div_t       dv_d     [0:was_pkg::DIV_STAGES];
    logic                out_valid;
    was_pkg::res_t       res;

    // advance the whole pipe unless a held result blocks the output
    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f0_reg.mode <= s_tuser;
            f0_reg.dir  <= s_tdata[1:0];
            f0_reg.dur  <= s_tdata[16:2];
            f0_reg.neg  <= s_tdata[64];
            f0_reg.ox   <= s_tdata[80:65];
            f0_reg.oy   <= s_tdata[96:81];
            f0_reg.ofg  <= s_tdata[104:97];
            f0_reg.ovis <= s_tdata[105];
            f0_reg.ww   <= s_tdata[121:106];
            f0_reg.wh   <= s_tdata[137:122];
            f0_reg.done <= s_tdata[138];
            el0_reg     <= s_tdata[64:17];
            d1_reg      <= d1_next;
        end
    end

    // divisor in microseconds; fade and slide treat negative time as zero
    always_comb begin
        logic [47:0] mag;
        logic        fs;
        mag = f0_reg.neg ? 48'(-el0_reg) : el0_reg;
        fs  = (f0_reg.mode == was_pkg::MODE_FADE_IN) ||
              (f0_reg.mode == was_pkg::MODE_FADE_OUT) ||
              (f0_reg.mode == was_pkg::MODE_SLIDE);
        d1_next.f    = f0_reg;
        d1_next.du   = 25'(f0_reg.dur) * 25'(was_pkg::US_PER_MS);
        d1_next.dvd  = (fs && f0_reg.neg) ? 48'd0 : mag;
        d1_next.rem  = '0;
        d1_next.qlsb = 1'b0;
        d1_next.qnz  = 1'b0;
    end

    assign dv_valid[0] = v1_reg;
    assign dv_d[0]     = d1_reg;

    for (genvar g = 0; g < was_pkg::DIV_STAGES; g++) begin : g_div
        was_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_valid[g]),
            .in_d      (dv_d[g]),
            .out_valid (dv_valid[g+1]),
            .out_d     (dv_d[g+1])
        );
    end

    was_tail u_tail (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid[was_pkg::DIV_STAGES]),
        .in_d      (dv_d[was_pkg::DIV_STAGES]),
        .out_valid (out_valid),
        .out_r     (res)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {5'b00000, res.running, res.done_out, res.visible,
                       res.fg_level, res.pos_y, res.pos_x};
    assign m_tuser  = res.write_mask;

endmodule
`default_nettype wire
